FILE: rtl/vedenc_pkg.sv
// Shared types and constants of the video-memory event delta encoder.
// No dependencies; every other file of the block imports this package.
package vedenc_pkg;

  // Largest encoded event in bytes, and the byte counts of its parts.
  localparam int ENC_MAX = 9;
  localparam int HDR_MAX = 4;
  localparam int PL_MAX  = 5;

  // Header format markers of the three-byte and four-byte forms.
  localparam logic [7:0] FMT_THREE = 8'hE0;
  localparam logic [7:0] FMT_FOUR  = 8'hF0;

  // Event kinds carried on in_tuser.
  localparam logic [1:0] FUNC_WORD   = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_ADJUST = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FLUSH      = 3'd0;
  localparam logic [2:0] CFG_ADJUST     = 3'd1;
  localparam logic [2:0] CFG_BYTE_FULL  = 3'd2;
  localparam logic [2:0] CFG_BYTE_DELTA = 3'd3;
  localparam logic [2:0] CFG_BYTE_ONE   = 3'd4;
  localparam logic [2:0] CFG_BYTE_AUTO  = 3'd5;
  localparam logic [2:0] CFG_WORD_FULL  = 3'd6;
  localparam logic [2:0] CFG_WORD_DELTA = 3'd7;

  localparam int CFG_NUM = 8;

  // Event type codes after reset, by register index.
  localparam logic [CFG_NUM-1:0][3:0] CODE_RESET = {
    4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd1, 4'd0
  };

  // One fully encoded event: bytes[0] leaves first, len is 1 to 9.
  typedef struct packed {
    logic [3:0]                 len;
    logic [ENC_MAX-1:0][7:0]    bytes;
  } enc_item_t;

endpackage

FILE: rtl/vedenc_front.sv
// Front end: accepts events, holds the code registers and the delta state,
// and encodes each event into one queue entry. Depends on vedenc_pkg.
module vedenc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [111:0]           in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  input  logic                   q_full,
  output logic                   q_push,
  output vedenc_pkg::enc_item_t  q_item
);
  import vedenc_pkg::*;

  logic [CFG_NUM-1:0][3:0] code_r, code_nxt;
  logic [31:0] last_cycle_r, last_cycle_nxt;
  logic [23:0] last_word_r, last_word_nxt;
  logic [15:0] last_byte_r, last_byte_nxt;

  logic [1:0]  func;
  logic [31:0] cycle;
  logic [23:0] address;
  logic [15:0] value;
  logic [7:0]  step;
  logic [31:0] deduction;
  logic [15:0] a16;

  logic        accept;
  logic [31:0] d;
  logic        d_big, d_short;
  logic [24:0] wdiff;
  logic [16:0] bdiff;
  logic        w_near, b_fwd, b_one, b_auto, b_near;
  logic [3:0]  code;

  logic [HDR_MAX-1:0][7:0] hdr;
  logic [2:0]              hlen;
  logic [PL_MAX-1:0][7:0]  pl;
  logic [2:0]              plen;
  logic [ENC_MAX-1:0][7:0] bytes;

  assign func      = in_tuser;
  assign cycle     = in_tdata[31:0];
  assign address   = in_tdata[55:32];
  assign value     = in_tdata[71:56];
  assign step      = in_tdata[79:72];
  assign deduction = in_tdata[111:80];
  assign a16       = address[15:0];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;
  assign cfg_ready = 1'b1;

  // Address deltas; a borrow means a backward step, which takes the full form.
  assign wdiff  = {1'b0, address} - {1'b0, last_word_r};
  assign w_near = !wdiff[24] && (wdiff[23:8] == 16'd0);
  assign bdiff  = {1'b0, a16} - {1'b0, last_byte_r};
  assign b_fwd  = !bdiff[16];
  assign b_one  = b_fwd && (bdiff[15:0] == 16'd1);
  assign b_auto = b_fwd && (bdiff[15:0] == {8'd0, step});
  assign b_near = b_fwd && (bdiff[15:8] == 8'd0);

  assign d       = cycle - last_cycle_r;
  assign d_big   = (d[31:16] != 16'd0);
  assign d_short = (d[31:5] == 27'd0) && d[4];

  // Event type code and payload.
  always_comb begin
    code = code_r[CFG_FLUSH];
    pl   = '0;
    plen = 3'd0;
    unique case (func)
      FUNC_WORD: begin
        if (w_near) begin
          code  = code_r[CFG_WORD_DELTA];
          pl[0] = wdiff[7:0];
          pl[1] = value[15:8];
          pl[2] = value[7:0];
          plen  = 3'd3;
        end else begin
          code  = code_r[CFG_WORD_FULL];
          pl[0] = address[23:16];
          pl[1] = address[15:8];
          pl[2] = address[7:0];
          pl[3] = value[15:8];
          pl[4] = value[7:0];
          plen  = 3'd5;
        end
      end
      FUNC_BYTE: begin
        priority if (b_one) begin
          code  = code_r[CFG_BYTE_ONE];
          pl[0] = value[7:0];
          plen  = 3'd1;
        end else if (b_auto) begin
          code  = code_r[CFG_BYTE_AUTO];
          pl[0] = value[7:0];
          plen  = 3'd1;
        end else if (b_near) begin
          code  = code_r[CFG_BYTE_DELTA];
          pl[0] = bdiff[7:0];
          pl[1] = value[7:0];
          plen  = 3'd2;
        end else begin
          code  = code_r[CFG_BYTE_FULL];
          pl[0] = a16[15:8];
          pl[1] = a16[7:0];
          pl[2] = value[7:0];
          plen  = 3'd3;
        end
      end
      FUNC_ADJUST: begin
        code  = code_r[CFG_ADJUST];
        pl[0] = deduction[31:24];
        pl[1] = deduction[23:16];
        pl[2] = deduction[15:8];
        pl[3] = deduction[7:0];
        plen  = 3'd4;
      end
      default: begin
        code = code_r[CFG_FLUSH];
      end
    endcase
  end

  // Header with the cycle delta since the last event.
  always_comb begin
    hdr = '0;
    priority if (d_big) begin
      hdr[0] = FMT_FOUR | {4'd0, code};
      hdr[1] = d[23:16];
      hdr[2] = d[15:8];
      hdr[3] = d[7:0];
      hlen   = 3'd4;
    end else if (d_short) begin
      hdr[0] = {code, d[3:0]};
      hlen   = 3'd1;
    end else begin
      hdr[0] = FMT_THREE | {4'd0, code};
      hdr[1] = d[15:8];
      hdr[2] = d[7:0];
      hlen   = 3'd3;
    end
  end

  // Payload bytes follow the header bytes directly.
  always_comb begin
    int j;
    for (int i = 0; i < ENC_MAX; i++) begin
      j = i - int'(hlen);
      if (i < int'(hlen)) begin
        bytes[i] = hdr[i[1:0]];
      end else if (j < PL_MAX) begin
        bytes[i] = pl[j[2:0]];
      end else begin
        bytes[i] = 8'd0;
      end
    end
  end

  assign q_item.bytes = bytes;
  assign q_item.len   = {1'b0, hlen} + {1'b0, plen};

  always_comb begin
    code_nxt       = code_r;
    last_cycle_nxt = last_cycle_r;
    last_word_nxt  = last_word_r;
    last_byte_nxt  = last_byte_r;
    if (cfg_valid) begin
      code_nxt[cfg_index] = cfg_data;
    end
    if (accept) begin
      unique case (func)
        FUNC_WORD: begin
          last_cycle_nxt = cycle;
          last_word_nxt  = address;
        end
        FUNC_BYTE: begin
          last_cycle_nxt = cycle;
          last_byte_nxt  = a16;
        end
        FUNC_ADJUST: begin
          last_cycle_nxt = cycle - deduction;
        end
        default: begin
          last_cycle_nxt = cycle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r       <= CODE_RESET;
      last_cycle_r <= '0;
      last_word_r  <= '0;
      last_byte_r  <= '0;
    end else begin
      code_r       <= code_nxt;
      last_cycle_r <= last_cycle_nxt;
      last_word_r  <= last_word_nxt;
      last_byte_r  <= last_byte_nxt;
    end
  end

endmodule

FILE: rtl/vedenc_fifo.sv
// Short queue of encoded events between the front end and the serializer.
// Depends on vedenc_pkg for the entry type.
module vedenc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  vedenc_pkg::enc_item_t  push_item,
  output logic                   full,
  input  logic                   pop,
  output vedenc_pkg::enc_item_t  pop_item,
  output logic                   empty
);
  import vedenc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  enc_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/vedenc_back.sv
// Back end: takes encoded events from the queue and sends them one byte per
// cycle while out_tready is high, from an output register. Depends on vedenc_pkg.
module vedenc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  vedenc_pkg::enc_item_t  q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);
  import vedenc_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [ENC_MAX-1:0][7:0] bytes_r, bytes_nxt;
  logic [3:0]              left_r, left_nxt;
  logic                    take, last, free;

  assign out_tvalid = busy_r;
  assign out_tdata  = bytes_r[0];
  assign last       = (left_r == 4'd1);
  assign out_tlast  = last;
  assign take       = busy_r && out_tready;
  // The next event loads in the cycle its predecessor's last byte leaves.
  assign free       = !busy_r || (take && last);
  assign q_pop      = free && !q_empty;

  always_comb begin
    busy_nxt  = busy_r;
    bytes_nxt = bytes_r;
    left_nxt  = left_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      bytes_nxt = q_item.bytes;
      left_nxt  = q_item.len;
    end else if (take) begin
      busy_nxt  = !last;
      bytes_nxt = bytes_r >> 8;
      left_nxt  = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

FILE: rtl/vram_event_delta_encoder.sv
// An accepted event is written into the queue and from there loaded into the output register.
// Bytes leave one per cycle while out_tready is high; an event has 1 to 9 bytes, sent by the
// single-byte output serializer. Events are accepted every cycle while the queue has room.
// Reset (rst_n low, synchronous) empties the queue, zeroes the cycle and address history
// and loads the default event type codes. Depends on vedenc_pkg, vedenc_front, vedenc_fifo
// and vedenc_back.
module vram_event_delta_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cycle[31:0], address[55:32], value[71:56], auto_increment[79:72], deduction[111:80]
  input  logic [111:0] in_tdata,
  // func[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_byte[7:0]
  output logic [7:0]   out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);
  import vedenc_pkg::*;

  enc_item_t push_item, pop_item;
  logic      q_full, q_push, q_pop, q_empty;

  vedenc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  vedenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  vedenc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_item     (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: sim/vedenc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for vram_event_delta_encoder: watches the event, result and code-write
// channels, predicts the encoded byte stream of every accepted event and compares it.
// Depends on vedenc_pkg for the event kinds, register indexes and reset codes.
module vedenc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // cycle[31:0], address[55:32], value[71:56], auto_increment[79:72], deduction[111:80]
  input  logic [111:0] in_tdata,
  // func[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // out_byte[7:0]
  input  logic [7:0]   out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data,
  output int           errors,
  output int           bytes_due,
  output int           bytes_seen
);
  import vedenc_pkg::*;

  localparam logic [31:0] LONG_GAP  = 32'd65535;
  localparam logic [31:0] NEAR_SPAN = 32'd256;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic [3:0]   type_code [CFG_NUM];
  logic [31:0]  prev_cycle;
  logic [23:0]  prev_word_addr;
  logic [15:0]  prev_byte_addr;
  logic [7:0]   frame [$];
  stream_byte_t stream_due [$];

  task automatic emit_header(input logic [3:0] code, input logic [31:0] cycle);
    logic [31:0] d;
    d = cycle - prev_cycle;
    if (d > LONG_GAP) begin
      // Bits 31..24 of a long gap are not sent.
      frame.push_back(FMT_FOUR | {4'h0, code});
      frame.push_back(d[23:16]);
      frame.push_back(d[15:8]);
      frame.push_back(d[7:0]);
    end else if (d >= 32'd16 && d <= 32'd31) begin
      // Short form: code in the high nibble, gap minus 16 in the low nibble.
      frame.push_back({code, d[3:0]});
    end else begin
      frame.push_back(FMT_THREE | {4'h0, code});
      frame.push_back(d[15:8]);
      frame.push_back(d[7:0]);
    end
  endtask

  task automatic encode_event(input logic [1:0] kind, input logic [111:0] data);
    logic [31:0]  cycle;
    logic [23:0]  address;
    logic [15:0]  value;
    logic [7:0]   step;
    logic [31:0]  deduction;
    logic [31:0]  gap;
    stream_byte_t sb;
    cycle     = data[31:0];
    address   = data[55:32];
    value     = data[71:56];
    step      = data[79:72];
    deduction = data[111:80];
    frame.delete();
    case (kind)
      FUNC_WORD: begin
        gap = {8'h00, address} - {8'h00, prev_word_addr};
        if (gap < NEAR_SPAN) begin
          emit_header(type_code[CFG_WORD_DELTA], cycle);
          frame.push_back(gap[7:0]);
        end else begin
          emit_header(type_code[CFG_WORD_FULL], cycle);
          frame.push_back(address[23:16]);
          frame.push_back(address[15:8]);
          frame.push_back(address[7:0]);
        end
        frame.push_back(value[15:8]);
        frame.push_back(value[7:0]);
        prev_cycle     = cycle;
        prev_word_addr = address;
      end
      FUNC_BYTE: begin
        gap = {16'h0000, address[15:0]} - {16'h0000, prev_byte_addr};
        // The step-one form wins over the auto-increment form when both match.
        if (gap == 32'd1) begin
          emit_header(type_code[CFG_BYTE_ONE], cycle);
        end else if (gap == {24'h000000, step}) begin
          emit_header(type_code[CFG_BYTE_AUTO], cycle);
        end else if (gap < NEAR_SPAN) begin
          emit_header(type_code[CFG_BYTE_DELTA], cycle);
          frame.push_back(gap[7:0]);
        end else begin
          emit_header(type_code[CFG_BYTE_FULL], cycle);
          frame.push_back(address[15:8]);
          frame.push_back(address[7:0]);
        end
        frame.push_back(value[7:0]);
        prev_cycle     = cycle;
        prev_byte_addr = address[15:0];
      end
      FUNC_ADJUST: begin
        emit_header(type_code[CFG_ADJUST], cycle);
        prev_cycle = cycle - deduction;
        frame.push_back(deduction[31:24]);
        frame.push_back(deduction[23:16]);
        frame.push_back(deduction[15:8]);
        frame.push_back(deduction[7:0]);
      end
      default: begin
        emit_header(type_code[CFG_FLUSH], cycle);
        prev_cycle = cycle;
      end
    endcase
    foreach (frame[i]) begin
      sb.data = frame[i];
      sb.last = (i == frame.size() - 1);
      stream_due.push_back(sb);
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      stream_due.delete();
      prev_cycle     = '0;
      prev_word_addr = '0;
      prev_byte_addr = '0;
      for (int i = 0; i < CFG_NUM; i++) type_code[i] = CODE_RESET[i];
      errors     = 0;
      bytes_seen = 0;
    end else begin
      // Results leave later than their event, through the queue and output register, so check before predicting.
      if (out_tvalid && out_tready) begin
        bytes_seen++;
        if (stream_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, got %02h last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = stream_due.pop_front();
          if (out_tdata !== want.data) begin
            errors++;
            $display("%0t: byte mismatch: expected %02h, got %02h", $time, want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, out_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) type_code[cfg_index] = cfg_data;
      if (in_tvalid && in_tready) encode_event(in_tuser, in_tdata);
    end
    bytes_due <= stream_due.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Simulation top for vram_event_delta_encoder: clock, reset, event and code-write
// stimulus, receiver stalls and the verdict. Depends on vedenc_pkg, the block and
// vedenc_checker, which does all prediction and comparison.
module testbench;
  import vedenc_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         out_tlast;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index  = '0;
  logic [3:0]   cfg_data   = '0;

  int errors;
  int bytes_due;
  int bytes_seen;

  // Shadow of the encoder history, used only to aim addresses and gaps at the boundaries.
  logic [31:0] cyc_base  = '0;
  logic [23:0] word_base = '0;
  logic [15:0] byte_base = '0;

  int burst_left    = 0;
  int kinds_sent [4];
  int settings_used = 0;
  int holds_asked   = 0;
  int holds_done    = 0;

  logic [CFG_NUM-1:0][3:0] mixed_codes;

  vram_event_delta_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  vedenc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .bytes_due  (bytes_due),
    .bytes_seen (bytes_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: switches among stall patterns, and on request holds off for a long stretch.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (left % 3 == 0);
      endcase
    end
  end

  // Offers one event at the given cycle gap after the current base and waits for it.
  task automatic send_event(input logic [1:0] kind, input logic [31:0] gap,
                            input logic [23:0] address, input logic [15:0] value,
                            input logic [7:0] step, input logic [31:0] deduction);
    logic [31:0] cycle;
    cycle = cyc_base + gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {deduction, step, value, address, cycle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    kinds_sent[kind]++;
    cyc_base = (kind == FUNC_ADJUST) ? cycle - deduction : cycle;
    if (kind == FUNC_WORD) word_base = address;
    if (kind == FUNC_BYTE) byte_base = address[15:0];
  endtask

  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    // The count seen here was taken at the previous edge, which includes the last item.
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
  endtask

  task automatic load_codes(input logic [CFG_NUM-1:0][3:0] codes);
    wait_idle();
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= codes[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic directed_events();
    // Header forms and word address forms.
    send_event(FUNC_WORD, 32'd0, 24'h000000, 16'h0000, 8'h00, 32'h0000_0000);
    send_event(FUNC_WORD, 32'd16, word_base + 24'd255, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_event(FUNC_WORD, 32'd31, word_base + 24'd256, 16'h8001, 8'h5A, 32'h1234_5678);
    send_event(FUNC_WORD, 32'd15, word_base - 24'd1, 16'h00FF, 8'h01, 32'h0);
    send_event(FUNC_WORD, 32'd32, 24'hFFFFFF, 16'h1234, 8'h80, 32'h0);
    send_event(FUNC_WORD, 32'd65535, 24'h000000, 16'hA5A5, 8'h00, 32'h0);
    send_event(FUNC_WORD, 32'd65536, 24'h000010, 16'h5A5A, 8'h00, 32'h0);
    send_event(FUNC_WORD, 32'hFFFF_FFFF, 24'h800000, 16'h0F0F, 8'h00, 32'h0);
    // Byte address forms, with the unused upper address and value bits set.
    send_event(FUNC_BYTE, 32'd20, {8'hAB, byte_base + 16'd1}, 16'hFF5A, 8'd3, 32'h0);
    send_event(FUNC_BYTE, 32'd21, {8'hFF, byte_base + 16'd3}, 16'h00A5, 8'd3, 32'h0);
    // Zero auto step: a write to the same address takes the auto form.
    send_event(FUNC_BYTE, 32'd22, {8'h00, byte_base}, 16'h1200, 8'd0, 32'h0);
    send_event(FUNC_BYTE, 32'd23, {8'h7F, byte_base + 16'd1}, 16'hFFFF, 8'd1, 32'h0);
    send_event(FUNC_BYTE, 32'd100, {8'h00, byte_base + 16'd255}, 16'h0080, 8'd7, 32'h0);
    send_event(FUNC_BYTE, 32'd100, {8'h01, byte_base + 16'd256}, 16'h0001, 8'd0, 32'h0);
    send_event(FUNC_BYTE, 32'd100, {8'h00, byte_base - 16'd1}, 16'h00FE, 8'hFF, 32'h0);
    send_event(FUNC_BYTE, 32'd3, 24'hFFFFFF, 16'h0011, 8'h00, 32'h0);
    // Stepping past the top of the 16-bit byte space goes backward and needs the full form.
    send_event(FUNC_BYTE, 32'd3, {8'h00, byte_base + 16'd1}, 16'h0022, 8'h01, 32'h0);
    // Adjusts rebase the cycle history.
    send_event(FUNC_ADJUST, 32'd40, 24'h123456, 16'hBEEF, 8'h44, 32'h0000_0000);
    send_event(FUNC_ADJUST, 32'd70000, 24'hFFFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_event(FUNC_ADJUST, 32'd5, 24'h000000, 16'h0000, 8'h00, 32'h89AB_CDEF);
    send_event(FUNC_FLUSH, 32'd0, 24'hFFFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_event(FUNC_FLUSH, 32'd24, 24'h000000, 16'h0000, 8'h00, 32'h0);
    send_event(FUNC_FLUSH, 32'd100000, 24'h5A5A5A, 16'h1234, 8'h12, 32'h0);
  endtask

  task automatic random_events(input int count);
    logic [1:0]  kind;
    logic [31:0] gap;
    logic [31:0] deduction;
    logic [23:0] address;
    logic [15:0] low;
    logic [7:0]  step;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? FUNC_BYTE : (pick < 7) ? FUNC_WORD :
             (pick < 8) ? FUNC_ADJUST : FUNC_FLUSH;
      case ($urandom_range(0, 5))
        0: gap = $urandom_range(0, 15);
        1: gap = $urandom_range(16, 31);
        2: gap = $urandom_range(32, 65535);
        3: gap = $urandom_range(65536, 32'hFFFF_FFFF);
        4: begin
          case ($urandom_range(0, 5))
            0:       gap = 32'd15;
            1:       gap = 32'd16;
            2:       gap = 32'd31;
            3:       gap = 32'd32;
            4:       gap = 32'd65535;
            default: gap = 32'd65536;
          endcase
        end
        default: gap = $urandom();
      endcase
      case ($urandom_range(0, 3))
        0:       step = 8'd0;
        1:       step = 8'd1;
        default: step = 8'($urandom());
      endcase
      if (kind == FUNC_WORD) begin
        case ($urandom_range(0, 4))
          0, 1:    address = word_base + 24'($urandom_range(0, 255));
          2:       address = word_base + 24'd256;
          3:       address = word_base - 24'($urandom_range(1, 300));
          default: address = 24'($urandom());
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       low = byte_base + 16'd1;
          1:       low = byte_base + 16'(step);
          2:       low = byte_base + 16'($urandom_range(0, 255));
          3:       low = byte_base + 16'd256;
          4:       low = byte_base - 16'($urandom_range(1, 300));
          default: low = 16'($urandom());
        endcase
        address = {8'($urandom()), low};
      end
      case ($urandom_range(0, 3))
        0:       deduction = $urandom_range(0, 1000);
        1:       deduction = 32'hFFFF_FFFF;
        2:       deduction = cyc_base + gap - $urandom_range(0, 40);
        default: deduction = $urandom();
      endcase
      send_event(kind, gap, address, 16'($urandom()), step, deduction);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) kinds_sent[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_events();
    random_events(60);

    // All codes at zero; the receiver holds off meanwhile, so the block must stall its input.
    load_codes('0);
    holds_asked <= holds_asked + 1;
    random_events(35);
    wait_idle();
    random_events(35);

    // Reserved codes at the top of the four-bit range.
    load_codes({4'd15, 4'd14, 4'd15, 4'd14, 4'd15, 4'd14, 4'd15, 4'd14});
    random_events(70);

    repeat (2) begin
      for (int i = 0; i < CFG_NUM; i++) mixed_codes[i] = 4'($urandom_range(0, 15));
      load_codes(mixed_codes);
      random_events(75);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d word, %0d byte, %0d adjust and %0d flush events under %0d code sets.",
             kinds_sent[FUNC_WORD], kinds_sent[FUNC_BYTE], kinds_sent[FUNC_ADJUST],
             kinds_sent[FUNC_FLUSH], settings_used + 1);
    $display("Checked %0d stream bytes, %0d errors.", bytes_seen, errors);
    if (errors == 0 && bytes_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
